### design/rwg_pkg.sv
`default_nettype none

package rwg_pkg;

  // default sizes, taken by the top level as its parameter defaults
  localparam int unsigned DefSineTableDepth = 1024;
  localparam int unsigned DefPhaseBits      = 32;

  // fixed field widths
  localparam int unsigned SampleW = 16;
  localparam int unsigned VolW    = 32;
  localparam int unsigned StepW   = 32;
  localparam int unsigned RomW    = 15;
  localparam int unsigned FactorW = 22;

  // queue depths
  localparam int unsigned MidDepth = 2;
  localparam int unsigned OutDepth = 8;

  // number formats
  localparam logic [VolW-1:0] VolFull    = '1;
  localparam int unsigned     HalfPiQ30  = 1686629713;
  localparam int unsigned     SineAmpMax = 32767;

  // wave shape codes
  localparam logic [1:0] ShapeSine   = 2'd0;
  localparam logic [1:0] ShapeSquare = 2'd1;
  localparam logic [1:0] ShapeSaw    = 2'd2;

  // register indexes
  localparam logic [1:0] RegWaveShape  = 2'd0;
  localparam logic [1:0] RegWidthMode  = 2'd1;
  localparam logic [1:0] RegPhaseStep  = 2'd2;
  localparam logic [1:0] RegVolumeStep = 2'd3;

  // configuration as seen by the datapath
  typedef struct packed {
    logic [1:0]       wave_shape;
    logic             eight_bit;
    logic [StepW-1:0] phase_step;
    logic [StepW-1:0] volume_step;
  } cfg_t;

endpackage

`default_nettype wire

### design/ramped_waveform_generator.sv
// ramped waveform generator: one sample per accepted beat
// path: an accepted beat goes through the middle queue, stages 1 to 3 and the result queue
// throughput: one beat per cycle while the queues have room, set by the single-add accumulators and the
//   3-stage index / table read / volume multiply pipeline
// reset: configuration, phase and volume clear to zero, both queues empty;
//   the sine table is a constant and needs no fill after reset
`default_nettype none

module ramped_waveform_generator #(
  parameter int unsigned SineTableDepth = rwg_pkg::DefSineTableDepth,
  parameter int unsigned PhaseBits      = rwg_pkg::DefPhaseBits
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // configuration
  input  wire logic                               cfg_we_i,
  input  wire logic [1:0]                         cfg_idx_i,
  input  wire logic [rwg_pkg::StepW-1:0]          cfg_data_i,
  // input beats
  input  wire logic                               push,
  output logic                                    full,
  input  wire logic                               restart_i,
  // result beats
  output logic                                    empty,
  input  wire logic                               pop,
  output logic signed [rwg_pkg::SampleW-1:0]      sample_value_o,
  output logic                                    ramp_full_o
);

  localparam int unsigned MidW = PhaseBits + rwg_pkg::VolW;

  rwg_pkg::cfg_t              cfg_q;
  logic                       mid_push, mid_pop, mid_empty, mid_full;
  logic [MidW-1:0]            mid_wdata, mid_rdata;
  logic [rwg_pkg::SampleW-1:0] sample;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rwg_pkg::RegWaveShape:  cfg_q.wave_shape  <= cfg_data_i[1:0];
        rwg_pkg::RegWidthMode:  cfg_q.eight_bit   <= cfg_data_i[0];
        rwg_pkg::RegPhaseStep:  cfg_q.phase_step  <= cfg_data_i;
        rwg_pkg::RegVolumeStep: cfg_q.volume_step <= cfg_data_i;
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  assign full = mid_full;

  // front: accumulators
  rwg_front #(
    .PhaseBits (PhaseBits)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .restart_i  (restart_i),
    .cfg_i      (cfg_q),
    .mid_full_i (mid_full),
    .mid_push_o (mid_push),
    .mid_data_o (mid_wdata)
  );

  // queue between front and back
  rwg_fifo #(
    .Width (MidW),
    .Depth (rwg_pkg::MidDepth)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .wdata_i (mid_wdata),
    .pop_i   (mid_pop),
    .rdata_o (mid_rdata),
    .empty_o (mid_empty),
    .full_o  (mid_full),
    .count_o ()
  );

  // back: waveform pipeline and result queue
  rwg_back #(
    .SineTableDepth (SineTableDepth),
    .PhaseBits      (PhaseBits)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .mid_empty_i (mid_empty),
    .mid_data_i  (mid_rdata),
    .mid_pop_o   (mid_pop),
    .pop         (pop),
    .empty       (empty),
    .sample_o    (sample),
    .ramp_full_o (ramp_full_o)
  );

  assign sample_value_o = $signed(sample);

endmodule

`default_nettype wire

### design/rwg_fifo.sv
`default_nettype none

module rwg_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push_i,
  input  wire logic [Width-1:0]           wdata_i,
  input  wire logic                       pop_i,
  output logic      [Width-1:0]           rdata_o,
  output logic                            empty_o,
  output logic                            full_o,
  output logic      [$clog2(Depth+1)-1:0] count_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth+1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(Depth));
  assign count_o = cnt_q;
  assign rdata_o = mem_q[rd_ptr_q];

  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  // pointer wrap and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth-1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth-1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

### design/rwg_front.sv
`default_nettype none

module rwg_front #(
  parameter int unsigned PhaseBits = rwg_pkg::DefPhaseBits
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 push,
  input  wire logic                                 restart_i,
  input  wire rwg_pkg::cfg_t                        cfg_i,
  input  wire logic                                 mid_full_i,
  output logic                                      mid_push_o,
  output logic [PhaseBits+rwg_pkg::VolW-1:0]        mid_data_o
);

  localparam int unsigned VolW = rwg_pkg::VolW;

  logic [PhaseBits-1:0] phase_q, phase_d, phase_cur;
  logic [VolW-1:0]      vol_q, vol_d, vol_cur;
  logic [VolW:0]        vol_sum;
  logic                 accept;

  assign accept     = push & ~mid_full_i;
  assign mid_push_o = accept;

  // restart clears both accumulators before this beat
  assign phase_cur  = restart_i ? '0 : phase_q;
  assign vol_cur    = restart_i ? '0 : vol_q;
  assign mid_data_o = {phase_cur, vol_cur};

  // phase wraps, volume saturates at full scale
  assign phase_d = phase_cur + PhaseBits'(cfg_i.phase_step);
  assign vol_sum = {1'b0, vol_cur} + {1'b0, cfg_i.volume_step};
  assign vol_d   = vol_sum[VolW] ? rwg_pkg::VolFull : vol_sum[VolW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      vol_q   <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      vol_q   <= vol_d;
    end
  end

endmodule

`default_nettype wire

### design/rwg_back.sv
`default_nettype none

module rwg_back #(
  parameter int unsigned SineTableDepth = rwg_pkg::DefSineTableDepth,
  parameter int unsigned PhaseBits      = rwg_pkg::DefPhaseBits
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire rwg_pkg::cfg_t                        cfg_i,
  input  wire logic                                 mid_empty_i,
  input  wire logic [PhaseBits+rwg_pkg::VolW-1:0]   mid_data_i,
  output logic                                      mid_pop_o,
  input  wire logic                                 pop,
  output logic                                      empty,
  output logic [rwg_pkg::SampleW-1:0]               sample_o,
  output logic                                      ramp_full_o
);

  localparam int unsigned VolW    = rwg_pkg::VolW;
  localparam int unsigned RomW    = rwg_pkg::RomW;
  localparam int unsigned FactorW = rwg_pkg::FactorW;
  localparam int unsigned SampleW = rwg_pkg::SampleW;
  localparam int unsigned ProdW   = FactorW + VolW;
  localparam int unsigned AW      = $clog2(SineTableDepth+1);
  localparam int unsigned RW      = PhaseBits - 2;
  localparam int unsigned JW      = RW + AW;
  localparam int unsigned OutW    = SampleW + 1;
  localparam int unsigned OutCntW = $clog2(rwg_pkg::OutDepth+1);

  typedef logic [RomW-1:0] rom_t [SineTableDepth+1];

  // one quarter-wave entry, Taylor series in Q2.30 through x^13
  function automatic logic [RomW-1:0] sine_entry(input int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] amp;
    x    = (64'(k) * 64'(rwg_pkg::HalfPiQ30)) / 64'(SineTableDepth);
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >> 30) / 6;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 20;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 42;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 72;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 110;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 156;
    sum  = sum + term;
    amp  = (sum * 64'(rwg_pkg::SineAmpMax) + (64'd1 << 29)) >> 30;
    if (amp > 64'(rwg_pkg::SineAmpMax)) begin
      amp = 64'(rwg_pkg::SineAmpMax);
    end
    return RomW'(amp);
  endfunction

  function automatic rom_t build_rom();
    rom_t rom;
    for (int unsigned k = 0; k <= SineTableDepth; k++) begin
      rom[k] = sine_entry(k);
    end
    return rom;
  endfunction

  localparam rom_t SineRom = build_rom();

  // stage valids
  logic s1_v_q, s2_v_q, s3_v_q;
  logic issue;

  // stage 1: table index, quadrant, volume
  logic [PhaseBits-1:0] in_phase;
  logic [VolW-1:0]      in_vol;
  logic [JW-1:0]        j_prod;
  logic [AW-1:0]        j_raw, j_clip;
  logic [AW-1:0]        s1_j_q;
  logic [1:0]           s1_quad_q;
  logic [15:0]          s1_top_q;
  logic [VolW-1:0]      s1_vol_q;

  // stage 2: table read
  logic [AW-1:0]        rom_addr;
  logic [RomW-1:0]      s2_amp_q;
  logic [1:0]           s2_quad_q;
  logic [15:0]          s2_top_q;
  logic [VolW-1:0]      s2_vol_q;

  // stage 3: scale by volume
  logic [FactorW-1:0]   factor;
  logic                 neg;
  logic [ProdW-1:0]     prod;
  logic [FactorW-1:0]   s3_hi_q;
  logic                 s3_neg_q;
  logic [7:0]           s3_saw8_q;
  logic                 s3_full_q;

  // finish and output queue
  logic [6:0]           q0;
  logic [15:0]          rem;
  logic [7:0]           m8;
  logic [SampleW-1:0]   mag16;
  logic [SampleW-1:0]   sample;
  logic [OutW-1:0]      out_rdata;
  logic [OutCntW-1:0]   out_cnt;
  logic [OutCntW:0]     committed;

  // issue only when the output queue has room for everything in flight
  assign committed = {1'b0, out_cnt} + (OutCntW+1)'(s1_v_q) + (OutCntW+1)'(s2_v_q)
                   + (OutCntW+1)'(s3_v_q);
  assign issue     = ~mid_empty_i & (committed < (OutCntW+1)'(rwg_pkg::OutDepth));
  assign mid_pop_o = issue;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      s1_v_q <= issue;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  // stage 1
  assign in_phase = mid_data_i[PhaseBits+VolW-1:VolW];
  assign in_vol   = mid_data_i[VolW-1:0];
  assign j_prod   = JW'(in_phase[RW-1:0]) * JW'(SineTableDepth);
  assign j_raw    = j_prod[JW-1:RW];
  assign j_clip   = (j_raw > AW'(SineTableDepth)) ? AW'(SineTableDepth) : j_raw;

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_j_q    <= j_clip;
      s1_quad_q <= in_phase[PhaseBits-1:PhaseBits-2];
      s1_top_q  <= in_phase[PhaseBits-1:PhaseBits-16];
      s1_vol_q  <= in_vol;
    end
  end

  // stage 2: mirrored index in odd quadrants
  assign rom_addr = s1_quad_q[0] ? (AW'(SineTableDepth) - s1_j_q) : s1_j_q;

  always_ff @(posedge clk_i) begin
    s2_amp_q  <= SineRom[rom_addr];
    s2_quad_q <= s1_quad_q;
    s2_top_q  <= s1_top_q;
    s2_vol_q  <= s1_vol_q;
  end

  // stage 3: pick the magnitude that multiplies the volume
  always_comb begin
    factor = '0;
    neg    = 1'b0;
    unique case (cfg_i.wave_shape)
      rwg_pkg::ShapeSine: begin
        neg    = s2_quad_q[1];
        factor = cfg_i.eight_bit ? ({s2_amp_q, 7'b0} - FactorW'(s2_amp_q))
                                 : FactorW'(s2_amp_q);
      end
      rwg_pkg::ShapeSquare: begin
        neg = s2_top_q[15];
        if (cfg_i.eight_bit) begin
          factor = s2_top_q[15] ? FactorW'(128) : FactorW'(127);
        end else begin
          factor = s2_top_q[15] ? FactorW'(32768) : FactorW'(32767);
        end
      end
      rwg_pkg::ShapeSaw: begin
        neg    = s2_top_q[15];
        factor = s2_top_q[15] ? FactorW'(17'h10000 - {1'b0, s2_top_q})
                              : FactorW'(s2_top_q);
      end
      default: begin
        factor = '0;
        neg    = 1'b0;
      end
    endcase
  end

  assign prod = ProdW'(factor) * ProdW'(s2_vol_q);

  always_ff @(posedge clk_i) begin
    s3_hi_q   <= prod[ProdW-1:VolW];
    s3_neg_q  <= neg;
    s3_saw8_q <= s2_top_q[15:8];
    s3_full_q <= (s2_vol_q == rwg_pkg::VolFull);
  end

  // divide by 32767 = 2^15 - 1: estimate from the top bits, one correction
  assign q0    = s3_hi_q[21:15];
  assign rem   = {1'b0, s3_hi_q[14:0]} + 16'(q0);
  assign m8    = (rem >= 16'd32767) ? (8'(q0) + 8'd1) : 8'(q0);
  assign mag16 = s3_hi_q[SampleW-1:0];

  // final sample format
  always_comb begin
    sample = '0;
    if (cfg_i.eight_bit) begin
      unique case (cfg_i.wave_shape)
        rwg_pkg::ShapeSine:   sample = s3_neg_q ? (16'd128 - 16'(m8)) : (16'd128 + 16'(m8));
        rwg_pkg::ShapeSquare: begin
          sample = s3_neg_q ? (16'd128 - 16'(s3_hi_q[7:0]))
                            : (16'd128 + 16'(s3_hi_q[7:0]));
        end
        rwg_pkg::ShapeSaw:    sample = 16'(s3_saw8_q);
        default:              sample = 16'd128;
      endcase
    end else begin
      unique case (cfg_i.wave_shape)
        rwg_pkg::ShapeSine,
        rwg_pkg::ShapeSquare,
        rwg_pkg::ShapeSaw:    sample = s3_neg_q ? (16'd0 - mag16) : mag16;
        default:              sample = '0;
      endcase
    end
  end

  // result queue
  rwg_fifo #(
    .Width (OutW),
    .Depth (rwg_pkg::OutDepth)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s3_v_q),
    .wdata_i ({sample, s3_full_q}),
    .pop_i   (pop),
    .rdata_o (out_rdata),
    .empty_o (empty),
    .full_o  (),
    .count_o (out_cnt)
  );

  assign sample_o    = out_rdata[OutW-1:1];
  assign ramp_full_o = out_rdata[0];

endmodule

`default_nettype wire
